>>> rtl/packed_varint_encoder_unit_assert.svh
// Assertion macros shared by the packed varint encoder RTL.
// Relies on clk_i and rst_ni being visible in the including module.
`ifndef PACKED_VARINT_ENCODER_UNIT_ASSERT_SVH
`define PACKED_VARINT_ENCODER_UNIT_ASSERT_SVH

// Checked property, disabled while reset is asserted.
`define PVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked property that also holds during reset.
`define PVE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/pve_pkg.sv
// Package for the packed varint encoder: constants, register indexes and the
// command and status structs between controller and datapath. No dependencies.
package pve_pkg;

  localparam int unsigned MaxElements = 1048575;

  localparam int unsigned CntW  = 20;
  localparam int unsigned OffW  = 24;
  localparam int unsigned ValW  = 64;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegWideMode     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegZigzagEnable = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPackedEnable = 2'd2;

  // Prefix width thresholds.
  localparam logic [OffW-1:0] Thresh1 = 24'h000080;
  localparam logic [OffW-1:0] Thresh2 = 24'h004000;
  localparam logic [OffW-1:0] Thresh3 = 24'h200000;

  typedef struct packed {
    logic load;
    logic emit_pay;
    logic emit_pfx;
  } pve_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic pay_more;
    logic pfx_needed;
    logic pfx_final;
  } pve_sts_t;

  function automatic logic [2:0] width_for(input logic [OffW-1:0] sz);
    logic [2:0] w;
    if (sz < Thresh1) begin
      w = 3'd1;
    end else if (sz < Thresh2) begin
      w = 3'd2;
    end else if (sz < Thresh3) begin
      w = 3'd3;
    end else begin
      w = 3'd4;
    end
    return w;
  endfunction

endpackage

>>> rtl/pve_ctrl.sv
// Controller of the packed varint encoder: sequences load, payload and prefix
// phases of one item. Depends on pve_pkg.
module pve_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pve_pkg::pve_sts_t sts_i,
  output pve_pkg::pve_cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPay  = 2'd1;
  localparam logic [1:0] StPfx  = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StPay;
        end
      end
      StPay: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_pay = 1'b1;
          if (!sts_i.pay_more) begin
            state_d = sts_i.pfx_needed ? StPfx : StIdle;
          end
        end
      end
      StPfx: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_pfx = 1'b1;
          if (sts_i.pfx_final) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/pve_dp.sv
// Datapath of the packed varint encoder: configuration, run state, value
// shifter, prefix builder and output register. Depends on pve_pkg.
module pve_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pve_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic                          cfg_data_i,
  input  logic [pve_pkg::ValW-1:0]      value_i,
  input  logic [pve_pkg::CntW-1:0]      element_count_i,
  input  logic                          first_element_i,
  input  logic                          last_element_i,
  input  pve_pkg::pve_cmd_t             cmd_i,
  output pve_pkg::pve_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic [pve_pkg::OffW-1:0]      byte_offset_o,
  output logic                          last_byte_o
);

  // Control state.
  logic                     wide_q, wide_d;
  logic                     zz_q, zz_d;
  logic                     pk_q, pk_d;
  logic [2:0]               pw_q, pw_d;
  logic [pve_pkg::OffW-1:0] pl_q, pl_d;
  logic                     out_valid_q, out_valid_d;

  // Per-item working registers.
  logic [pve_pkg::ValW-1:0] val_q, val_d;
  logic [3:0]               grp_q, grp_d;
  logic [pve_pkg::OffW-1:0] off_q, off_d;
  logic                     last_q, last_d;
  logic                     cnt_en_q, cnt_en_d;
  logic [1:0]               idx_q, idx_d;
  logic [7:0]               out_byte_q, out_byte_d;
  logic [pve_pkg::OffW-1:0] out_off_q, out_off_d;
  logic                     out_last_q, out_last_d;

  logic [pve_pkg::ValW-1:0] mapped;
  logic [31:0]              v32;
  logic [pve_pkg::OffW-1:0] cnt_sat;
  logic [pve_pkg::OffW-1:0] run_size;
  logic [2:0]               new_pw;
  logic                     pay_more;
  logic [7:0]               pay_byte;
  logic                     pfx_needed;
  logic                     pfx_final;
  logic [6:0]               pfx_grp;

  // Zigzag mapping, if enabled, and cut to the selected width.
  always_comb begin
    v32 = value_i[31:0];
    if (wide_q) begin
      mapped = zz_q ? ({value_i[62:0], 1'b0} ^ {pve_pkg::ValW{value_i[63]}}) : value_i;
    end else if (zz_q) begin
      mapped = {32'd0, {v32[30:0], 1'b0} ^ {32{v32[31]}}};
    end else begin
      mapped = {32'd0, v32};
    end
  end

  // Prefix width from the saturated count times 5 or 10 bytes.
  always_comb begin
    cnt_sat = {4'd0, element_count_i};
    if (cnt_sat > pve_pkg::OffW'(pve_pkg::MaxElements)) begin
      cnt_sat = pve_pkg::OffW'(pve_pkg::MaxElements);
    end
    run_size = (cnt_sat << 2) + cnt_sat;
    if (wide_q) begin
      run_size = run_size << 1;
    end
    new_pw = pve_pkg::width_for(run_size);
  end

  // A group with bit 7 set follows while the rest does not fit, up to nine.
  assign pay_more   = (val_q[pve_pkg::ValW-1:7] != '0) && (grp_q != 4'd9);
  assign pay_byte   = pay_more ? {1'b1, val_q[6:0]} : val_q[7:0];
  assign pfx_needed = last_q && (pw_q != 3'd0);
  assign pfx_final  = ({1'b0, idx_q} + 3'd1) == pw_q;

  always_comb begin
    case (idx_q)
      2'd0:    pfx_grp = pl_q[6:0];
      2'd1:    pfx_grp = pl_q[13:7];
      2'd2:    pfx_grp = pl_q[20:14];
      default: pfx_grp = {4'd0, pl_q[23:21]};
    endcase
  end

  always_comb begin
    wide_d      = wide_q;
    zz_d        = zz_q;
    pk_d        = pk_q;
    pw_d        = pw_q;
    pl_d        = pl_q;
    val_d       = val_q;
    grp_d       = grp_q;
    off_d       = off_q;
    last_d      = last_q;
    cnt_en_d    = cnt_en_q;
    idx_d       = idx_q;
    out_byte_d  = out_byte_q;
    out_off_d   = out_off_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        pve_pkg::RegWideMode:     wide_d = cfg_data_i;
        pve_pkg::RegZigzagEnable: zz_d   = cfg_data_i;
        pve_pkg::RegPackedEnable: pk_d   = cfg_data_i;
        default: ;
      endcase
    end

    if (cmd_i.load) begin
      val_d    = mapped;
      grp_d    = 4'd0;
      idx_d    = 2'd0;
      cnt_en_d = pk_q;
      last_d   = pk_q && last_element_i;
      if (!pk_q) begin
        off_d = '0;
      end else if (first_element_i && last_element_i && (element_count_i == '0)) begin
        // Empty run: a lone zero byte at offset zero and the run closes.
        val_d    = '0;
        off_d    = '0;
        last_d   = 1'b0;
        cnt_en_d = 1'b0;
        pw_d     = 3'd0;
        pl_d     = '0;
      end else if (first_element_i) begin
        pw_d  = new_pw;
        pl_d  = '0;
        off_d = {21'd0, new_pw};
      end else begin
        off_d = {21'd0, pw_q} + pl_q;
      end
    end

    if (cmd_i.emit_pay) begin
      out_byte_d  = pay_byte;
      out_off_d   = off_q;
      out_last_d  = !pay_more && !pfx_needed;
      out_valid_d = 1'b1;
      val_d       = val_q >> 7;
      grp_d       = grp_q + 4'd1;
      off_d       = off_q + 1'b1;
      if (cnt_en_q) begin
        pl_d = pl_q + 1'b1;
      end
      if (!pay_more && last_q && !pfx_needed) begin
        pw_d = 3'd0;
        pl_d = '0;
      end
    end

    if (cmd_i.emit_pfx) begin
      out_byte_d  = {!pfx_final, pfx_grp};
      out_off_d   = {22'd0, idx_q};
      out_last_d  = pfx_final;
      out_valid_d = 1'b1;
      idx_d       = idx_q + 2'd1;
      if (pfx_final) begin
        pw_d = 3'd0;
        pl_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q      <= 1'b1;
      zz_q        <= 1'b0;
      pk_q        <= 1'b1;
      pw_q        <= 3'd0;
      pl_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wide_q      <= wide_d;
      zz_q        <= zz_d;
      pk_q        <= pk_d;
      pw_q        <= pw_d;
      pl_q        <= pl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    grp_q      <= grp_d;
    off_q      <= off_d;
    last_q     <= last_d;
    cnt_en_q   <= cnt_en_d;
    idx_q      <= idx_d;
    out_byte_q <= out_byte_d;
    out_off_q  <= out_off_d;
    out_last_q <= out_last_d;
  end

  assign sts_o.slot_free  = !out_valid_q || !out_stall_i;
  assign sts_o.pay_more   = pay_more;
  assign sts_o.pfx_needed = pfx_needed;
  assign sts_o.pfx_final  = pfx_final;

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_offset_o = out_off_q;
  assign last_byte_o   = out_last_q;

endmodule

>>> rtl/packed_varint_encoder_unit.sv
// Top level of the packed varint encoder: controller plus datapath.
// Depends on pve_pkg, pve_ctrl, pve_dp and packed_varint_encoder_unit_assert.svh.
//
// The encoder takes one integer per input transfer and produces its base-128
// varint bytes, least significant group first, one output transfer per byte,
// each tagged with its offset in the encoded run and a flag on the final byte
// of the item. Values may be zigzag-mapped and cut to 32 or 64 bits. In packed
// mode the first element of a run reserves a 1 to 4 byte length prefix at
// offset zero, sized from the element count times 5 or 10; the payload follows
// it, and the last element appends the prefix bytes carrying the real payload
// length, padded with continuation bits to the reserved width. An empty run
// (first and last with a zero count) yields a single zero byte. In unpacked
// mode each value stands alone from offset zero. An item is first loaded and
// then yields its payload bytes followed by any prefix bytes; the single
// output register is filled with one byte per cycle while the output side
// does not stall. A new item is taken as soon as the last byte of the
// previous one sits in the output register, even if it is still waiting to
// be transferred. Configuration writes take effect at once and should only
// be made while the block is idle.
module packed_varint_encoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port.
  input  logic                        cfg_we_i,
  input  logic [pve_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic                        cfg_data_i,
  // Input channel.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pve_pkg::ValW-1:0]    value_i,
  input  logic [pve_pkg::CntW-1:0]    element_count_i,
  input  logic                        first_element_i,
  input  logic                        last_element_i,
  // Output channel.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  out_byte_o,
  output logic [pve_pkg::OffW-1:0]    byte_offset_o,
  output logic                        last_byte_o
);

  `include "packed_varint_encoder_unit_assert.svh"

  pve_pkg::pve_cmd_t cmd;
  pve_pkg::pve_sts_t sts;

  // The controller owns sequencing; it accepts an item only when idle.
  pve_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds configuration, run state and the output register.
  pve_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .value_i         (value_i),
    .element_count_i (element_count_i),
    .first_element_i (first_element_i),
    .last_element_i  (last_element_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .byte_offset_o   (byte_offset_o),
    .last_byte_o     (last_byte_o)
  );

  // After an accepted item the block is busy until it has produced its bytes.
  `PVE_ASSERT(a_busy_after_load, (in_valid_i && !in_stall_o) |=> in_stall_o, "not busy after load")
  // Prefix bytes are only emitted for a closing element with a reserved prefix.
  `PVE_ASSERT(a_pfx_needs_width, cmd.emit_pfx |-> sts.pfx_needed, "prefix without width")
  // Once reset has been seen at an edge, no byte is offered at the next one.
  `PVE_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |=> !out_valid_o, "output valid in reset")

endmodule
